FILE: hw/rtl/oled_page_framebuffer_refresh_core_macros.svh
// Assertion macros shared by the frame store refresh core
`ifndef OLED_PAGE_FRAMEBUFFER_REFRESH_CORE_MACROS_SVH
`define OLED_PAGE_FRAMEBUFFER_REFRESH_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define OPFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("opfr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define OPFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("opfr: next-cycle check failed");

`endif

FILE: hw/rtl/opfr_pkg.sv
// Package: constants, codes and shared types of the frame store refresh core
`default_nettype none
package opfr_pkg;

	localparam int COLUMNS_DEF   = 128;
	localparam int PAGES_DEF     = 8;
	localparam int ROWS_PER_PAGE = 8;
	localparam int CMD_SLOTS     = 3;

	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_LOW   = 8'h00;
	localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
	localparam logic [7:0] PIX_TOP_MASK  = 8'h80;

	// Operation codes of an input transaction
	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_DRAW    = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_REFRESH = 2'd3
	} op_t;

	// Controller to datapath commands
	typedef struct packed {
		logic ready;
		logic accept;
		logic exec;
		logic clr_run;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
		logic clr_last;
		logic clear_op;
	} dp_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/opfr_ifs.sv
// Handshake interfaces for the input and result channels
`default_nettype none
interface opfr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] col;
	logic [7:0] row;
	logic       pixel_on;

	modport source (output valid, operation, col, row, pixel_on, input ready);
	modport sink   (input valid, operation, col, row, pixel_on, output ready);
endinterface

interface opfr_out_if;
	logic       valid;
	logic       ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       is_data;
	logic       frame_last;
	logic       busy_res;

	modport source (output valid, out_valid, out_byte, is_data, frame_last, busy_res,
		input ready);
	modport sink   (input valid, out_valid, out_byte, is_data, frame_last, busy_res,
		output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/opfr_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port
`default_nettype none
module opfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/opfr_ctrl.sv
// Controller: sequences accept, execute and store clearing sweeps
`default_nettype none
module opfr_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire opfr_pkg::dp_stat_t   stat,
	output opfr_pkg::ctrl_cmd_t       cmd
);
	import opfr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EXEC  = 3'b010,
		ST_CLEAR = 3'b100
	} state_t;

	state_t state_q, state_nxt;

	// Commands: take a transaction only when idle and the result slot is free
	always_comb begin
		cmd.ready   = (state_q == ST_IDLE) && stat.out_free;
		cmd.accept  = cmd.ready && in_valid;
		cmd.exec    = (state_q == ST_EXEC);
		cmd.clr_run = (state_q == ST_CLEAR);
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_nxt = stat.clear_op ? ST_CLEAR : ST_IDLE;
			end
			ST_CLEAR: begin
				if (stat.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	// Reset starts with a sweep that blanks the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/opfr_datapath.sv
// Datapath: transfer counters, pixel update, byte generation and result register
`default_nettype none
module opfr_datapath #(
	parameter int COLUMNS = opfr_pkg::COLUMNS_DEF,
	parameter int PAGES   = opfr_pkg::PAGES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire opfr_pkg::ctrl_cmd_t cmd,
	output opfr_pkg::dp_stat_t       stat,
	opfr_in_if.sink                  item,
	opfr_out_if.source               result
);
	import opfr_pkg::*;

	localparam int DEPTH = COLUMNS * PAGES;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(COLUMNS);
	localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int BW    = $clog2(COLUMNS + CMD_SLOTS);

	localparam logic [8:0]    COL_LIM   = 9'(COLUMNS);
	localparam logic [8:0]    ROW_LIM   = 9'(ROWS_PER_PAGE * PAGES);
	localparam logic [BW-1:0] BIP_LAST  = BW'(COLUMNS + CMD_SLOTS - 1);
	localparam logic [BW-1:0] BIP_DATA  = BW'(CMD_SLOTS);
	localparam logic [PW-1:0] PAGE_LAST = PW'(PAGES - 1);
	localparam logic [AW-1:0] CLR_LAST  = AW'(DEPTH - 1);

	// Transfer position
	logic          active_q;
	logic [PW-1:0] page_q;
	logic [BW-1:0] bip_q;
	logic [AW-1:0] clr_cnt_q;
	logic          res_vld_q;

	// Item held for the execute cycle
	op_t           op_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    mask_s1;
	logic          on_s1;
	logic          draw_ok_s1;
	logic          use_ram_s1;
	logic          vld_s1;
	logic [7:0]    byte_s1;
	logic          data_s1;
	logic          last_s1;
	logic          busy_s1;

	// Result register
	logic       r_out_valid_q;
	logic [7:0] r_out_byte_q;
	logic       r_is_data_q;
	logic       r_frame_last_q;
	logic       r_busy_res_q;

	op_t           op_in;
	logic          draw_ok;
	logic [PW-1:0] draw_page;
	logic [AW-1:0] draw_addr;
	logic [7:0]    draw_mask;
	logic          tick_data;
	logic [CW-1:0] tick_col;
	logic [AW-1:0] tick_addr;
	logic [7:0]    cmd_byte;
	logic          bip_wrap;
	logic          page_wrap;
	logic          tick_last;
	logic          busy_nxt;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	assign op_in = op_t'(item.operation);

	// Draw: range check, page and bit of the pixel
	always_comb begin
		draw_ok   = ({1'b0, item.col} < COL_LIM) && ({1'b0, item.row} < ROW_LIM);
		draw_page = PAGE_LAST - item.row[3 +: PW];
		draw_mask = PIX_TOP_MASK >> item.row[2:0];
		draw_addr = AW'(item.col[CW-1:0]) * AW'(PAGES) + AW'(draw_page);
	end

	// Tick: command slot or data slot of the current page
	always_comb begin
		tick_data = (bip_q >= BIP_DATA);
		tick_col  = CW'(bip_q - BIP_DATA);
		tick_addr = AW'(tick_col) * AW'(PAGES) + AW'(page_q);
		bip_wrap  = (bip_q == BIP_LAST);
		page_wrap = (page_q == PAGE_LAST);
		tick_last = active_q && bip_wrap && page_wrap;
		if (bip_q == BW'(0)) begin
			cmd_byte = CMD_PAGE_BASE + 8'(page_q);
		end else if (bip_q == BW'(1)) begin
			cmd_byte = CMD_COL_LOW;
		end else begin
			cmd_byte = CMD_COL_HIGH;
		end
	end

	// Transfer state after this transaction
	always_comb begin
		case (op_in)
			OP_CLEAR, OP_REFRESH: busy_nxt = 1'b1;
			OP_TICK:              busy_nxt = active_q && !tick_last;
			default:              busy_nxt = active_q;
		endcase
	end

	// Transfer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			page_q   <= '0;
			bip_q    <= '0;
		end else if (cmd.accept) begin
			case (op_in)
				OP_CLEAR, OP_REFRESH: begin
					active_q <= 1'b1;
					page_q   <= '0;
					bip_q    <= '0;
				end
				OP_TICK: begin
					if (active_q) begin
						if (bip_wrap) begin
							bip_q <= '0;
							if (page_wrap) begin
								page_q   <= '0;
								active_q <= 1'b0;
							end else begin
								page_q <= page_q + PW'(1);
							end
						end else begin
							bip_q <= bip_q + BW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Capture the item for the execute cycle
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_s1      <= op_in;
			addr_s1    <= draw_addr;
			mask_s1    <= draw_mask;
			on_s1      <= item.pixel_on;
			draw_ok_s1 <= draw_ok;
			use_ram_s1 <= (op_in == OP_TICK) && active_q && tick_data;
			vld_s1     <= (op_in == OP_TICK) && active_q;
			byte_s1    <= ((op_in == OP_TICK) && active_q) ? cmd_byte : 8'h00;
			data_s1    <= (op_in == OP_TICK) && active_q && tick_data;
			last_s1    <= (op_in == OP_TICK) && tick_last;
			busy_s1    <= busy_nxt;
		end
	end

	// Store read at accept, write on draw or during a clearing sweep
	always_comb begin
		ram_re    = cmd.accept && (op_in == OP_DRAW || (op_in == OP_TICK && active_q));
		ram_raddr = (op_in == OP_DRAW) ? draw_addr : tick_addr;
		if (cmd.clr_run) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = 8'h00;
		end else begin
			ram_we    = cmd.exec && (op_s1 == OP_DRAW) && draw_ok_s1;
			ram_waddr = addr_s1;
			ram_wdata = on_s1 ? (ram_rdata | mask_s1) : (ram_rdata & ~mask_s1);
		end
	end

	opfr_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_run) begin
			clr_cnt_q <= (clr_cnt_q == CLR_LAST) ? '0 : clr_cnt_q + AW'(1);
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (cmd.exec) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			r_out_valid_q  <= vld_s1;
			r_out_byte_q   <= use_ram_s1 ? ram_rdata : byte_s1;
			r_is_data_q    <= data_s1;
			r_frame_last_q <= last_s1;
			r_busy_res_q   <= busy_s1;
		end
	end

	assign item.ready        = cmd.ready;
	assign result.valid      = res_vld_q;
	assign result.out_valid  = r_out_valid_q;
	assign result.out_byte   = r_out_byte_q;
	assign result.is_data    = r_is_data_q;
	assign result.frame_last = r_frame_last_q;
	assign result.busy_res   = r_busy_res_q;

	assign stat.out_free = !res_vld_q || result.ready;
	assign stat.clr_last = (clr_cnt_q == CLR_LAST);
	assign stat.clear_op = (op_s1 == OP_CLEAR);

endmodule
`default_nettype wire

FILE: hw/rtl/oled_page_framebuffer_refresh_core.sv
// Top level: page-mode frame store with byte-serial display refresh
//
//   Channel   Dir   Payload                                        Transaction
//   item      in    operation, col, row, pixel_on                  valid & ready
//   result    out   out_valid, out_byte, is_data, frame_last,      valid & ready
//                   busy_res
//
// An item is accepted in the idle state, then the execute state finishes the store
// read and loads the result register, as the store's read port is registered.
// A clear item is followed by a sweep zeroing COLUMNS*PAGES bytes (1024 by default).
// After reset the same sweep runs before the first item is taken.
// A waiting result holds off the next item until it is taken.
`default_nettype none
`include "oled_page_framebuffer_refresh_core_macros.svh"
module oled_page_framebuffer_refresh_core #(
	parameter int COLUMNS = opfr_pkg::COLUMNS_DEF,
	parameter int PAGES   = opfr_pkg::PAGES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	opfr_in_if.sink    item,
	opfr_out_if.source result
);
	import opfr_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	opfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.stat     (stat),
		.cmd      (cmd)
	);

	opfr_datapath #(
		.COLUMNS (COLUMNS),
		.PAGES   (PAGES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.item   (item),
		.result (result)
	);

	// Checks
	`OPFR_ASSERT_NOW(a_no_accept_in_sweep, clk, arst_n, cmd.clr_run, !item.ready)
	`OPFR_ASSERT_NEXT(a_accept_then_exec, clk, arst_n, item.valid && item.ready, cmd.exec)
	`OPFR_ASSERT_NEXT(a_exec_then_result, clk, arst_n, cmd.exec, result.valid)
	`OPFR_ASSERT_NOW(a_last_ends_busy, clk, arst_n, result.valid && result.frame_last,
		!result.busy_res && result.is_data)

endmodule
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the page-mode frame store refresh core
module testbench;
	import opfr_pkg::*;

	localparam int NCOLS       = 128;
	localparam int NPAGES      = 8;
	localparam int FB_BYTES    = NCOLS * NPAGES;
	localparam int PAGE_SLOTS  = CMD_SLOTS + NCOLS;
	localparam int FRAME_TICKS = NPAGES * PAGE_SLOTS;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 20;

	// One input transaction
	typedef struct {
		op_t        op;
		logic [7:0] col;
		logic [7:0] row;
		logic       pix_on;
	} disp_cmd_t;

	// One result transaction
	typedef struct {
		logic       out_valid;
		logic [7:0] out_byte;
		logic       is_data;
		logic       frame_last;
		logic       busy_res;
	} disp_byte_t;

	logic clk;
	logic arst_n;
	int   cycle_count;
	int   error_count;

	opfr_in_if  item_ch ();
	opfr_out_if res_ch ();

	oled_page_framebuffer_refresh_core #(
		.COLUMNS(NCOLS),
		.PAGES  (NPAGES)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(res_ch)
	);

	// Shadow of the frame store and the refresh position
	logic [7:0]  shadow_fb [0:FB_BYTES-1];
	bit          xfer_on;
	int unsigned xfer_page;
	int unsigned xfer_slot;

	disp_cmd_t  cmds_to_send [$];
	disp_byte_t display_bytes_due [$];

	// Driver bookkeeping
	disp_cmd_t cmd_in_flight;
	int        burst_left;
	int        gap_left;
	logic      next_valid;

	// Receiver stall pattern
	logic [15:0] stall_pat;
	int          pat_age;

	always #5 clk = ~clk;

	// Work out the display byte that one command produces, updating the shadow state
	function automatic disp_byte_t predict_display_byte(input disp_cmd_t c);
		disp_byte_t  r;
		int unsigned pg;
		int unsigned idx;
		logic [7:0]  mask;
		r = '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0};
		case (c.op)
			OP_DRAW: begin
				if (c.col < NCOLS && c.row < NPAGES * ROWS_PER_PAGE) begin
					pg   = NPAGES - 1 - c.row / ROWS_PER_PAGE;
					mask = PIX_TOP_MASK >> (c.row % ROWS_PER_PAGE);
					idx  = c.col * NPAGES + pg;
					if (c.pix_on)
						shadow_fb[idx] = shadow_fb[idx] | mask;
					else
						shadow_fb[idx] = shadow_fb[idx] & ~mask;
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < FB_BYTES; i++)
					shadow_fb[i] = 8'h00;
				xfer_on   = 1'b1;
				xfer_page = 0;
				xfer_slot = 0;
			end
			OP_REFRESH: begin
				xfer_on   = 1'b1;
				xfer_page = 0;
				xfer_slot = 0;
			end
			default: begin
				if (xfer_on) begin
					r.out_valid = 1'b1;
					if (xfer_slot == 0)
						r.out_byte = CMD_PAGE_BASE + 8'(xfer_page);
					else if (xfer_slot == 1)
						r.out_byte = CMD_COL_LOW;
					else if (xfer_slot == 2)
						r.out_byte = CMD_COL_HIGH;
					else begin
						r.is_data  = 1'b1;
						r.out_byte = shadow_fb[(xfer_slot - CMD_SLOTS) * NPAGES + xfer_page];
					end
					xfer_slot++;
					if (xfer_slot >= PAGE_SLOTS) begin
						xfer_slot = 0;
						xfer_page++;
						if (xfer_page >= NPAGES) begin
							xfer_page    = 0;
							xfer_on      = 1'b0;
							r.frame_last = 1'b1;
						end
					end
				end
			end
		endcase
		r.busy_res = xfer_on;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		$display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
	endtask

	task automatic queue_cmd(input op_t op, input int col, input int row, input int pix_on);
		disp_cmd_t c;
		c.op     = op;
		c.col    = 8'(col);
		c.row    = 8'(row);
		c.pix_on = 1'(pix_on);
		cmds_to_send.push_back(c);
	endtask

	// Mostly on-screen coordinates, now and then past the edge
	function automatic int pick_col();
		return ($urandom_range(0, 6) == 0) ? $urandom_range(128, 255) : $urandom_range(0, 127);
	endfunction

	function automatic int pick_row();
		return ($urandom_range(0, 6) == 0) ? $urandom_range(64, 255) : $urandom_range(0, 63);
	endfunction

	task automatic queue_random_draw();
		queue_cmd(OP_DRAW, pick_col(), pick_row(), ($urandom_range(0, 9) < 7) ? 1 : 0);
	endtask

	// Driver: feeds command transactions in bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid     <= 1'b0;
			item_ch.operation <= OP_TICK;
			item_ch.col       <= 8'h00;
			item_ch.row       <= 8'h00;
			item_ch.pixel_on  <= 1'b0;
			burst_left = 1;
			gap_left   = 0;
		end else begin
			next_valid = item_ch.valid;
			if (item_ch.valid && item_ch.ready) begin
				display_bytes_due.push_back(predict_display_byte(cmd_in_flight));
				next_valid = 1'b0;
				if (burst_left > 1)
					burst_left--;
				else begin
					// a third of bursts are long and back to back
					if ($urandom_range(0, 2) == 0) begin
						burst_left = $urandom_range(20, 60);
						gap_left   = 0;
					end else begin
						burst_left = $urandom_range(1, 12);
						gap_left   = $urandom_range(1, 8);
					end
				end
			end
			if (!next_valid) begin
				if (gap_left > 0)
					gap_left--;
				else if (cmds_to_send.size() > 0) begin
					cmd_in_flight = cmds_to_send.pop_front();
					next_valid    = 1'b1;
					item_ch.operation <= cmd_in_flight.op;
					item_ch.col       <= cmd_in_flight.col;
					item_ch.row       <= cmd_in_flight.row;
					item_ch.pixel_on  <= cmd_in_flight.pix_on;
				end
			end
			item_ch.valid <= next_valid;
		end
	end

	// Monitor: checks result transactions, stalls on a rotating pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_pat = 16'hFFFF;
			pat_age   = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (display_bytes_due.size() == 0)
					report_mismatch("result with nothing expected, byte",
						int'(res_ch.out_byte), 0);
				else begin
					disp_byte_t w;
					w = display_bytes_due.pop_front();
					if (res_ch.out_valid !== w.out_valid)
						report_mismatch("out_valid", int'(res_ch.out_valid),
							int'(w.out_valid));
					if (res_ch.out_byte !== w.out_byte)
						report_mismatch("out_byte", int'(res_ch.out_byte),
							int'(w.out_byte));
					if (res_ch.is_data !== w.is_data)
						report_mismatch("is_data", int'(res_ch.is_data),
							int'(w.is_data));
					if (res_ch.frame_last !== w.frame_last)
						report_mismatch("frame_last", int'(res_ch.frame_last),
							int'(w.frame_last));
					if (res_ch.busy_res !== w.busy_res)
						report_mismatch("busy_res", int'(res_ch.busy_res),
							int'(w.busy_res));
				end
			end
			// new pattern each time pat_age wraps; a third of them never stall
			if (pat_age == 63) begin
				pat_age = 0;
				if ($urandom_range(0, 2) == 0)
					stall_pat = 16'hFFFF;
				else begin
					stall_pat    = 16'($urandom);
					stall_pat[0] = 1'b1;
				end
			end else
				pat_age++;
			res_ch.ready <= stall_pat[0];
			stall_pat = {stall_pat[0], stall_pat[15:1]};
		end
	end

	// Run-time guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int r;
		clk               = 1'b0;
		arst_n            = 1'b0;
		cycle_count       = 0;
		error_count       = 0;
		item_ch.valid     = 1'b0;
		item_ch.operation = OP_TICK;
		item_ch.col       = 8'h00;
		item_ch.row       = 8'h00;
		item_ch.pixel_on  = 1'b0;
		res_ch.ready      = 1'b0;
		for (int i = 0; i < FB_BYTES; i++)
			shadow_fb[i] = 8'h00;
		xfer_on   = 1'b0;
		xfer_page = 0;
		xfer_slot = 0;

		// Directed: idle tick, corner pixels, off-screen draws
		queue_cmd(OP_TICK, 0, 0, 0);
		queue_cmd(OP_DRAW, 0, 0, 1);
		queue_cmd(OP_DRAW, 127, 63, 1);
		queue_cmd(OP_DRAW, 128, 0, 1);
		queue_cmd(OP_DRAW, 255, 255, 1);
		queue_cmd(OP_DRAW, 0, 64, 1);
		queue_cmd(OP_DRAW, 5, 10, 1);
		queue_cmd(OP_DRAW, 5, 10, 0);
		queue_cmd(OP_DRAW, 0, 7, 1);
		// refresh: three command bytes then the first columns of page 0
		queue_cmd(OP_REFRESH, 0, 0, 0);
		for (int i = 0; i < 5; i++)
			queue_cmd(OP_TICK, 0, 0, 0);
		// draw ahead of the transfer, then restart part way through
		queue_cmd(OP_DRAW, 2, 56, 1);
		queue_cmd(OP_TICK, 0, 0, 0);
		queue_cmd(OP_REFRESH, 0, 0, 0);
		queue_cmd(OP_TICK, 0, 0, 0);
		queue_cmd(OP_CLEAR, 0, 0, 0);
		for (int i = 0; i < 5; i++)
			queue_cmd(OP_TICK, 0, 0, 0);

		// Random: fill the screen with some pixels, then one whole frame with draws mixed in
		for (int i = 0; i < 50; i++)
			queue_random_draw();
		queue_cmd(OP_REFRESH, 0, 0, 0);
		for (int i = 0; i < FRAME_TICKS; i++) begin
			if ($urandom_range(0, 9) == 0)
				queue_random_draw();
			queue_cmd(OP_TICK, 0, 0, 0);
		end
		// Random: loose mix with restarts, idle ticks and clears
		for (int i = 0; i < 130; i++) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				queue_cmd(OP_TICK, $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 1));
			else if (r < 85)
				queue_random_draw();
			else if (r < 93)
				queue_cmd(OP_REFRESH, 0, 0, 0);
			else
				queue_cmd(OP_CLEAR, 0, 0, 0);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (cmds_to_send.size() != 0 || item_ch.valid)
			@(posedge clk);
		while (display_bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/opfr_pkg.sv
hw/rtl/opfr_ifs.sv
hw/rtl/opfr_ram.sv
hw/rtl/opfr_ctrl.sv
hw/rtl/opfr_datapath.sv
hw/rtl/oled_page_framebuffer_refresh_core.sv
dv/testbench.sv
